### rtl/sdfg_pkg.sv
package sdfg_pkg;

   // decade positions and the longest character run of one item
   localparam int NUM_POS   = 10;
   localparam int MAX_CHARS = 14;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int POS_W     = $clog2(NUM_POS);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_POS - 1);

   // field code and control byte encodings
   localparam logic [7:0] FREE_CODE   = 8'h0b;
   localparam logic [7:0] CTL_BASE    = 8'h0a;
   localparam logic [7:0] CTL_FREE    = 8'h80;
   localparam logic [7:0] CTL_STARTED = 8'h40;
   localparam logic [7:0] CTL_SIGN    = 8'h20;
   localparam logic [7:0] CTL_PAD     = 8'h8f;

   // ascii codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // multiples 1..9 of each decade divisor, 36 bits so 9 * 10^9 fits
   typedef logic [NUM_POS-1:0][8:0][35:0] step_table_type;

   function automatic step_table_type build_steps();
      step_table_type t;
      logic [35:0]    d;
      t = '0;
      for (int p = 0; p < NUM_POS; p++) begin
         d = 36'd1;
         for (int e = 0; e < NUM_POS - 1 - p; e++) begin
            d = d * 36'd10;
         end
         for (int k = 0; k < 9; k++) begin
            t[p][k] = d * 36'(k + 1);
         end
      end
      return t;
   endfunction

   localparam step_table_type STEP_TABLE = build_steps();

   // comma goes before the 10^8, 10^5 and 10^2 digits
   function automatic logic is_group_pos(input logic [POS_W-1:0] pos);
      return (pos == POS_W'(1)) || (pos == POS_W'(4)) || (pos == POS_W'(7));
   endfunction

   // item record handed from cell to cell
   typedef struct packed {
      logic                           valid;
      logic [31:0]                    mag;
      logic [7:0]                     ctl;
      logic                           comma_en;
      logic [CNT_W-1:0]               cnt;
      logic [MAX_CHARS-1:0][7:0]      chars;
   } cell_rec_type;

endpackage

### rtl/sdfg_cell.sv
module sdfg_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [sdfg_pkg::POS_W-1:0] pos,
   input  sdfg_pkg::cell_rec_type     prev_rec,
   output sdfg_pkg::cell_rec_type     cell_rec
);
   import sdfg_pkg::*;

   cell_rec_type rec_ff;
   cell_rec_type rec_in;
   logic [3:0]   digit;
   logic [31:0]  sub_val;
   logic         emit;

   // digit by parallel compares against the decade multiples
   always_comb begin
      digit = '0;
      for (int k = 0; k < 9; k++) begin
         if ({4'b0, prev_rec.mag} >= STEP_TABLE[pos][k]) begin
            digit = 4'(k + 1);
         end
      end
   end

   assign sub_val = (digit == 4'd0) ? 32'd0 : STEP_TABLE[pos][4'(digit - 4'd1)][31:0];
   assign emit    = (pos == LAST_POS) || (digit != 4'd0) || prev_rec.ctl[6];

   // control byte update and character appends for this decade
   always_comb begin
      rec_in     = prev_rec;
      rec_in.mag = prev_rec.mag - sub_val;
      if (!emit) begin
         if ((rec_in.ctl & CTL_PAD) == 8'h00) begin
            rec_in.chars = {rec_in.chars[MAX_CHARS-2:0], CHAR_SPACE};
            rec_in.cnt   = rec_in.cnt + CNT_W'(1);
         end
         if (rec_in.ctl[3:0] != 4'd0) begin
            rec_in.ctl = rec_in.ctl - 8'd1;
         end
      end else if (rec_in.ctl[3:0] != 4'd0) begin
         rec_in.ctl = (rec_in.ctl | CTL_STARTED) - 8'd1;
      end else begin
         if ((rec_in.ctl & CTL_SIGN) != 8'h00) begin
            rec_in.ctl   = rec_in.ctl - CTL_SIGN;
            rec_in.chars = {rec_in.chars[MAX_CHARS-2:0], CHAR_MINUS};
            rec_in.cnt   = rec_in.cnt + CNT_W'(1);
         end
         if (is_group_pos(pos) && rec_in.ctl[6] && rec_in.comma_en) begin
            rec_in.chars = {rec_in.chars[MAX_CHARS-2:0], CHAR_COMMA};
            rec_in.cnt   = rec_in.cnt + CNT_W'(1);
         end
         rec_in.ctl   = rec_in.ctl | CTL_STARTED;
         rec_in.chars = {rec_in.chars[MAX_CHARS-2:0], CHAR_ZERO + {4'b0, digit}};
         rec_in.cnt   = rec_in.cnt + CNT_W'(1);
      end
   end

   // stage register, moves whenever the chain advances
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (advance) begin
         rec_ff <= rec_in;
      end
   end

   assign cell_rec = rec_ff;

endmodule

### rtl/sdfg_serializer.sv
module sdfg_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sdfg_pkg::cell_rec_type rec,
   output logic                   free,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_char_valid,
   output logic                   rsp_last_char
);
   import sdfg_pkg::*;

   logic [CNT_W-1:0]          remain_ff;
   logic [CNT_W-1:0]          remain_in;
   logic [MAX_CHARS-1:0][7:0] buf_ff;
   logic                      empty_ff;

   // remaining results; an empty run still sends one marker
   always_comb begin
      if (load) begin
         remain_in = (rec.cnt == '0) ? CNT_W'(1) : rec.cnt;
      end else if (remain_ff != '0) begin
         remain_in = remain_ff - CNT_W'(1);
      end else begin
         remain_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   // character buffer, oldest character at the highest filled slot
   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff   <= rec.chars;
         empty_ff <= (rec.cnt == '0);
      end
   end

   assign free           = (remain_ff <= CNT_W'(1));
   assign rsp_strobe     = (remain_ff != '0);
   assign rsp_char_valid = !empty_ff;
   assign rsp_last_char  = (remain_ff == CNT_W'(1));
   assign rsp_out_char   = empty_ff ? 8'h00 : buf_ff[4'(remain_ff - CNT_W'(1))];

endmodule

### rtl/signed_decimal_formatter_grouped.sv
// Signed decimal formatter with optional thousands grouping.
// Input channel: drive req_value, req_field_code and req_format_flags with
// start high; the item is taken at a rising edge where busy is low.
// Result channel: one character per cycle on rsp_out_char, marked by
// rsp_strobe, with rsp_char_valid and rsp_last_char; a run that writes no
// character gives a single result with rsp_char_valid low.
// The item walks a row of ten decade cells, one cell per cycle while the
// chain advances, then loads the output serializer, which puts its first
// character on the result ports.
// The serializer sends one result per cycle, so an item holds the chain
// until it has sent one result per character (up to 14), or one marker.
// The chain moves on until an item waits for the serializer at its end, so
// items queue up to ten deep; a new item is taken when the serializer frees.
// Reset clears all valid state in the cells and the serializer and holds
// busy high; nothing is sent until a new item arrives. The receiver has no
// way to stall results: each one is present for exactly one cycle.
module signed_decimal_formatter_grouped (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_field_code,
   input  logic [1:0]         req_format_flags,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_char_valid,
   output logic               rsp_last_char
);
   import sdfg_pkg::*;

   cell_rec_type chain [NUM_POS+1];
   logic         advance;
   logic         ser_free;
   logic         neg;
   logic [7:0]   ctl_base;
   logic [7:0]   ctl_sign;
   logic [7:0]   ctl_init;

   // chain moves unless its last item waits for the serializer
   assign advance = !chain[NUM_POS].valid || ser_free;
   assign busy    = reset || !advance;

   // initial control byte from field code, sign and zero padding
   assign neg      = req_value[31];
   assign ctl_base = (req_field_code == FREE_CODE) ? CTL_FREE : CTL_BASE - req_field_code;

   always_comb begin
      ctl_sign = ctl_base;
      if (neg) begin
         ctl_sign = ctl_base + CTL_SIGN;
         if (!ctl_sign[7]) begin
            ctl_sign = ctl_sign + 8'd1;
         end
      end
      ctl_init = req_format_flags[1] ? (ctl_sign | CTL_STARTED) : ctl_sign;
   end

   // record entering the first cell
   always_comb begin
      chain[0].valid    = start && advance;
      chain[0].mag      = neg ? (32'd0 - $unsigned(req_value)) : $unsigned(req_value);
      chain[0].ctl      = ctl_init;
      chain[0].comma_en = req_format_flags[0];
      chain[0].cnt      = '0;
      chain[0].chars    = '0;
   end

   // one cell per decade position, most significant first
   for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
      sdfg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .pos      (POS_W'(i)),
         .prev_rec (chain[i]),
         .cell_rec (chain[i+1])
      );
   end

   // output serializer
   sdfg_serializer u_ser (
      .clock          (clock),
      .reset          (reset),
      .load           (chain[NUM_POS].valid && ser_free),
      .rec            (chain[NUM_POS]),
      .free           (ser_free),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last_char  (rsp_last_char)
   );

endmodule
